@@ sv/led_blink_pattern_sequencer_core_defines.svh @@
// Assertion macros shared by the LED blink pattern sequencer RTL.
// Expects signals named clock and reset in the module that uses them.
`ifndef LED_BLINK_PATTERN_SEQUENCER_CORE_DEFINES_SVH
`define LED_BLINK_PATTERN_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication.
`define LBPS_ASSERT_NOW(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define LBPS_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ sv/lbps_pkg.sv @@
// Types, constants and pattern ROM of the LED blink pattern sequencer.
// No dependencies.
package lbps_pkg;

   localparam int NOW_WIDTH    = 32;
   localparam int MASK_WIDTH   = 4;
   localparam int PID_WIDTH    = 3;
   localparam int LED_WIDTH    = 4;
   localparam int IDX_WIDTH    = 6;
   localparam int BYTE_WIDTH   = 8;
   localparam int OFF_WIDTH    = 5;
   localparam int NUM_PATTERNS = 5;
   localparam int ROM_LEN      = 37;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam logic [PID_WIDTH-1:0]  PAT_OFF      = 3'd0;
   localparam logic [BYTE_WIDTH-1:0] MARK_RESTART = 8'd255;
   localparam logic [BYTE_WIDTH-1:0] MARK_POP     = 8'd254;

   typedef struct packed {
      logic                 command;
      logic                 load_ok;
      logic [PID_WIDTH-1:0] pid;
   } cmd_type;

   localparam int CMD_BITS = $bits(cmd_type);

   localparam logic [BYTE_WIDTH-1:0] ROM [ROM_LEN] = '{
      8'd0, 8'd0, 8'd0, 8'd255,
      8'd1, 8'd0, 8'd0, 8'd255,
      8'd1, 8'd2, 8'd125, 8'd62, 8'd255,
      8'd1, 8'd2, 8'd125, 8'd0, 8'd255,
      8'd1, 8'd1, 8'd200, 8'd50, 8'd200, 8'd50, 8'd200, 8'd50, 8'd200, 8'd50,
      8'd200, 8'd50, 8'd200, 8'd50, 8'd200, 8'd50, 8'd200, 8'd50, 8'd254
   };

   function automatic logic [BYTE_WIDTH-1:0] rom_at(input logic [IDX_WIDTH-1:0] idx);
      if (int'(idx) < ROM_LEN) begin
         return ROM[idx];
      end
      return MARK_RESTART;
   endfunction

   function automatic logic [IDX_WIDTH-1:0] start_of(input logic [PID_WIDTH-1:0] id);
      case (id)
         3'd0: return 6'd0;
         3'd1: return 6'd4;
         3'd2: return 6'd8;
         3'd3: return 6'd13;
         3'd4: return 6'd18;
         default: return 6'd0;
      endcase
   endfunction

   function automatic logic [2:0] chan_bit(input logic [2:0] c);
      case (c)
         3'd0: return 3'd3;
         3'd1: return 3'd1;
         3'd2: return 3'd2;
         3'd3: return 3'd0;
         default: return c;
      endcase
   endfunction

   function automatic logic [OFF_WIDTH-1:0] chan_off(input logic [2:0] c);
      case (c)
         3'd0: return 5'd2;
         3'd1: return 5'd5;
         3'd2: return 5'd3;
         3'd3: return 5'd7;
         3'd4: return 5'd11;
         3'd5: return 5'd13;
         3'd6: return 5'd17;
         default: return 5'd19;
      endcase
   endfunction

endpackage

@@ sv/led_blink_pattern_sequencer_core.sv @@
// LED blink pattern sequencer: front classifier, two-entry queue, back end.
// Path: a request is written into the queue, then the back end registers its result.
// Throughput: one item per cycle while the result is not stalled.
// Reset: synchronous; every channel plays 'off', deadline half range minus two,
// queue and result register empty. Depends on lbps_pkg and the submodules.
module led_blink_pattern_sequencer_core #(
   parameter int CHANNELS    = 4,
   parameter int STACK_DEPTH = 3,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [lbps_pkg::NOW_WIDTH-1:0]  req_now,
   input  logic [lbps_pkg::MASK_WIDTH-1:0] req_channel_mask,
   input  logic [lbps_pkg::PID_WIDTH-1:0]  req_pattern_id,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lbps_pkg::LED_WIDTH-1:0]  rsp_led_levels,
   output logic [lbps_pkg::LED_WIDTH-1:0]  rsp_driven_mask
);
   import lbps_pkg::*;

   localparam int ITEM_WIDTH = CMD_BITS + CHANNELS + TIME_WIDTH;

   cmd_type                 f_cmd, q_cmd;
   logic [CHANNELS-1:0]     f_sel, q_sel;
   logic [TIME_WIDTH-1:0]   f_now, q_now;
   logic [ITEM_WIDTH-1:0]   f_item, q_item;
   logic                    q_valid, q_stall;

   lbps_front #(
      .CHANNELS   (CHANNELS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .req_command      (req_command),
      .req_now          (req_now),
      .req_channel_mask (req_channel_mask),
      .req_pattern_id   (req_pattern_id),
      .cmd              (f_cmd),
      .sel              (f_sel),
      .now              (f_now)
   );

   assign f_item = {f_cmd, f_sel, f_now};

   lbps_queue #(
      .WIDTH (ITEM_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (f_item),
      .out_valid (q_valid),
      .out_stall (q_stall),
      .out_data  (q_item)
   );

   assign {q_cmd, q_sel, q_now} = q_item;

   lbps_back #(
      .CHANNELS    (CHANNELS),
      .STACK_DEPTH (STACK_DEPTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_stall         (q_stall),
      .q_cmd           (q_cmd),
      .q_sel           (q_sel),
      .q_now           (q_now),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_led_levels  (rsp_led_levels),
      .rsp_driven_mask (rsp_driven_mask)
   );

endmodule

@@ sv/lbps_front.sv @@
// Front end: classifies a request and maps the LED mask onto channels.
// Depends on lbps_pkg.
module lbps_front #(
   parameter int CHANNELS   = 4,
   parameter int TIME_WIDTH = 32
) (
   input  logic                               req_command,
   input  logic [lbps_pkg::NOW_WIDTH-1:0]     req_now,
   input  logic [lbps_pkg::MASK_WIDTH-1:0]    req_channel_mask,
   input  logic [lbps_pkg::PID_WIDTH-1:0]     req_pattern_id,
   output lbps_pkg::cmd_type                  cmd,
   output logic [CHANNELS-1:0]                sel,
   output logic [TIME_WIDTH-1:0]              now
);
   import lbps_pkg::*;

   localparam int MASK_IDX_WIDTH = $clog2(MASK_WIDTH);

   always_comb begin
      cmd.command = req_command;
      cmd.load_ok = int'(req_pattern_id) < NUM_PATTERNS;
      cmd.pid     = req_pattern_id;
      for (int c = 0; c < CHANNELS; c++) begin
         sel[c] = 1'b0;
         if (int'(chan_bit(3'(c))) < MASK_WIDTH) begin
            sel[c] = req_channel_mask[MASK_IDX_WIDTH'(chan_bit(3'(c)))];
         end
      end
   end

   generate
      if (TIME_WIDTH > NOW_WIDTH) begin : g_wide
         assign now = {{(TIME_WIDTH - NOW_WIDTH){1'b0}}, req_now};
      end else if (TIME_WIDTH == NOW_WIDTH) begin : g_same
         assign now = req_now;
      end else begin : g_narrow
         assign now = req_now[TIME_WIDTH-1:0];
      end
   endgenerate

endmodule

@@ sv/lbps_queue.sv @@
// Two-entry queue between front and back ends.
// Depends on the assertion macro header.
module lbps_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [WIDTH-1:0] out_data
);
   `include "led_blink_pattern_sequencer_core_defines.svh"

   localparam logic [1:0] DEPTH = 2'd2;

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_stall  = count_ff == DEPTH;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   `LBPS_ASSERT_NEXT(a_q_fill, push && !pop, count_ff == $past(count_ff) + 2'd1, "queue fill")
   `LBPS_ASSERT_NEXT(a_q_drain, pop && !push, count_ff == $past(count_ff) - 2'd1, "queue drain")
   `LBPS_ASSERT_NOW(a_q_ptrs, count_ff == 2'd0 || count_ff == DEPTH, wr_ptr_ff == rd_ptr_ff, "queue ptr")

endmodule

@@ sv/lbps_back.sv @@
// Back end: per-channel pattern state, serve and load, registered result.
// Depends on lbps_pkg and the assertion macro header.
module lbps_back #(
   parameter int CHANNELS    = 4,
   parameter int STACK_DEPTH = 3,
   parameter int TIME_WIDTH  = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_stall,
   input  lbps_pkg::cmd_type               q_cmd,
   input  logic [CHANNELS-1:0]             q_sel,
   input  logic [TIME_WIDTH-1:0]           q_now,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lbps_pkg::LED_WIDTH-1:0]  rsp_led_levels,
   output logic [lbps_pkg::LED_WIDTH-1:0]  rsp_driven_mask
);
   import lbps_pkg::*;
   `include "led_blink_pattern_sequencer_core_defines.svh"

   localparam logic [TIME_WIDTH-1:0] THALF    = {1'b0, {(TIME_WIDTH - 1){1'b1}}};
   localparam logic [TIME_WIDTH-1:0] TFOREVER = THALF - {{(TIME_WIDTH - 1){1'b0}}, 1'b1};

   typedef logic [STACK_DEPTH-1:0][PID_WIDTH-1:0] stack_type;

   logic [TIME_WIDTH-1:0] deadline_ff   [CHANNELS];
   logic [TIME_WIDTH-1:0] deadline_in   [CHANNELS];
   logic [IDX_WIDTH-1:0]  read_index_ff [CHANNELS];
   logic [IDX_WIDTH-1:0]  read_index_in [CHANNELS];
   stack_type             stack_ff      [CHANNELS];
   stack_type             stack_in      [CHANNELS];
   logic [1:0]            shift_ff      [CHANNELS];
   logic [1:0]            shift_in      [CHANNELS];
   logic [CHANNELS-1:0]   next_level_ff, next_level_in;
   logic [CHANNELS-1:0]   level_ff, level_in;
   logic [CHANNELS-1:0]   driven;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LED_WIDTH-1:0]  levels_ff, levels_in;
   logic [LED_WIDTH-1:0]  mask_ff, mask_in;
   logic                  advance;

   assign advance         = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_stall         = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_led_levels  = levels_ff;
   assign rsp_driven_mask = mask_ff;

   always_comb begin
      stack_type             stk;
      logic [TIME_WIDTH-1:0] dl;
      logic [TIME_WIDTH-1:0] diff;
      logic [IDX_WIDTH-1:0]  ri;
      logic [IDX_WIDTH-1:0]  start;
      logic [BYTE_WIDTH-1:0] mark;
      logic [BYTE_WIDTH-1:0] b0;
      logic [BYTE_WIDTH-1:0] b1;
      logic [BYTE_WIDTH-1:0] dbyte;
      logic [1:0]            sc;
      logic                  nl;
      logic                  lvl;
      driven = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         stk   = stack_ff[c];
         dl    = deadline_ff[c];
         ri    = read_index_ff[c];
         sc    = shift_ff[c];
         nl    = next_level_ff[c];
         lvl   = level_ff[c];
         diff  = q_now - dl;
         start = start_of(q_cmd.pid);
         mark  = rom_at(ri);
         b0    = '0;
         b1    = '0;
         dbyte = '0;
         if (q_cmd.command == CMD_LOAD) begin
            if (q_sel[c] && q_cmd.load_ok) begin
               dl = q_now + TIME_WIDTH'(chan_off(3'(c)));
               for (int k = STACK_DEPTH - 1; k > 0; k--) begin
                  stk[k] = stk[k-1];
               end
               stk[0] = q_cmd.pid;
               b0 = rom_at(start);
               b1 = rom_at(start + IDX_WIDTH'(1));
               nl = b0[0];
               sc = b1[1:0];
               ri = start + IDX_WIDTH'(2);
            end
         end else if (diff < THALF) begin
            if (mark == MARK_RESTART || mark == MARK_POP) begin
               if (mark == MARK_POP) begin
                  for (int k = 0; k < STACK_DEPTH - 1; k++) begin
                     stk[k] = stk[k+1];
                  end
                  stk[STACK_DEPTH-1] = PAT_OFF;
               end
               start = start_of(stk[0]);
               b0 = rom_at(start);
               b1 = rom_at(start + IDX_WIDTH'(1));
               nl = b0[0];
               sc = b1[1:0];
               ri = start + IDX_WIDTH'(2);
            end
            lvl   = nl;
            nl    = ~nl;
            dbyte = rom_at(ri);
            ri    = ri + IDX_WIDTH'(1);
            if (dbyte == '0) begin
               dl = dl + TFOREVER;
            end else begin
               dl = dl + TIME_WIDTH'({3'b000, dbyte} << sc);
            end
            driven[c] = 1'b1;
         end
         stack_in[c]      = stk;
         deadline_in[c]   = dl;
         read_index_in[c] = ri;
         shift_in[c]      = sc;
         next_level_in[c] = nl;
         level_in[c]      = lvl;
      end
   end

   always_comb begin
      levels_in = '0;
      mask_in   = '0;
      for (int i = 0; i < CHANNELS && i < LED_WIDTH; i++) begin
         levels_in[i] = level_in[i];
         mask_in[i]   = driven[i];
      end
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            deadline_ff[c]   <= TFOREVER;
            read_index_ff[c] <= start_of(PAT_OFF) + IDX_WIDTH'(2);
            stack_ff[c]      <= '0;
            shift_ff[c]      <= 2'd0;
         end
         next_level_ff <= '0;
         level_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            for (int c = 0; c < CHANNELS; c++) begin
               deadline_ff[c]   <= deadline_in[c];
               read_index_ff[c] <= read_index_in[c];
               stack_ff[c]      <= stack_in[c];
               shift_ff[c]      <= shift_in[c];
            end
            next_level_ff <= next_level_in;
            level_ff      <= level_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         levels_ff <= levels_in;
         mask_ff   <= mask_in;
      end
   end

   `LBPS_ASSERT_NEXT(a_bk_load_quiet, advance && q_cmd.command == CMD_LOAD, mask_ff == '0, "load drove")
   `LBPS_ASSERT_NEXT(a_bk_result, advance, rsp_valid_ff, "result lost")
   `LBPS_ASSERT_NEXT(a_bk_arm,
      advance && q_cmd.command == CMD_LOAD && q_cmd.load_ok && q_sel[0],
      deadline_ff[0] == $past(q_now) + TIME_WIDTH'(chan_off(3'd0)), "arm deadline")

endmodule
